// ===== hw/rtl/gsk_pkg.sv =====
// gsk_pkg: shared types and key compare for the group sort core
// depends on nothing; used by gsk_cell and group_sort_by_position_key_core
package gsk_pkg;

   localparam int CHROM_W = 16;
   localparam int POS_W   = 31;
   localparam int IDX_W   = 6;

   typedef struct packed {
      logic [CHROM_W-1:0] chromosome;
      logic [POS_W-1:0]   position;
      logic               last_record;
   } req_word_type;

   typedef struct packed {
      logic [CHROM_W-1:0] group_chrom;
      logic [POS_W-1:0]   group_position;
      logic [IDX_W-1:0]   variant_index;
      logic [IDX_W-1:0]   group_number;
      logic               end_of_group;
      logic               end_of_run;
      logic               overflow;
   } rsp_word_type;

   // one stored variant record
   typedef struct packed {
      logic [CHROM_W-1:0] chrom;
      logic [POS_W-1:0]   pos;
      logic [IDX_W-1:0]   idx;
   } entry_type;

   // chain-wide control from the top level
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // strict order on (chrom, pos); ties fall behind existing entries
   function automatic logic key_less(entry_type a, entry_type b);
      logic result;
      if (a.chrom != b.chrom) begin
         result = (a.chrom < b.chrom);
      end else begin
         result = (a.pos < b.pos);
      end
      return result;
   endfunction

   function automatic logic key_same(entry_type a, entry_type b);
      return (a.chrom == b.chrom) && (a.pos == b.pos);
   endfunction

endpackage

// ===== hw/rtl/gsk_cell.sv =====
// gsk_cell: one slot of the sorted insertion chain
// depends on gsk_pkg
module gsk_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  gsk_pkg::cell_ctrl_type ctrl,
   input  gsk_pkg::entry_type     new_entry,
   input  gsk_pkg::entry_type     prev_entry,
   input  logic                   prev_valid,
   input  logic                   prev_take,
   input  gsk_pkg::entry_type     next_entry,
   input  logic                   next_valid,
   output gsk_pkg::entry_type     entry,
   output logic                   valid,
   output logic                   take
);

   gsk_pkg::entry_type entry_ff, entry_in;
   logic               valid_ff, valid_in;

   // new record belongs at or before this slot
   assign take = !valid_ff || gsk_pkg::key_less(new_entry, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.drain) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctrl.insert && take) begin
         if (prev_take) begin
            entry_in = prev_entry;
            valid_in = prev_valid;
         end else begin
            entry_in = new_entry;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

// ===== hw/rtl/group_sort_by_position_key_core.sv =====
// group_sort_by_position_key_core: stable sort of variant records into key groups
// loading takes one word per cycle; the drain delivers one result word per cycle while rsp_ready allows
// after the last record is accepted, state_ff enters drain, then the head fills the output register
// requests are refused (req_ready low) until the drain has delivered the whole run
// reset: synchronous, clears the chain valid bits, count, flags and state
// depends on gsk_pkg and gsk_cell
module group_sort_by_position_key_core #(
   parameter int MAX_VARIANTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gsk_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gsk_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
   localparam int IDX_W = gsk_pkg::IDX_W;

   // chain of cells, slot 0 holds the smallest key
   gsk_pkg::entry_type    cell_entry [MAX_VARIANTS];
   logic                  cell_valid [MAX_VARIANTS];
   logic                  cell_take  [MAX_VARIANTS];
   gsk_pkg::cell_ctrl_type ctrl;
   gsk_pkg::entry_type    new_entry;

   gsk_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_seen_ff, ovf_seen_in;
   logic                  ovf_hold_ff, ovf_hold_in;
   logic [IDX_W-1:0]      grp_ff, grp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gsk_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic                  full;
   logic                  pop;
   logic                  head_end_run;
   logic                  head_end_grp;

   assign full      = (count_ff == CNT_W'(MAX_VARIANTS));
   assign accept    = req_valid && req_ready;

   // the new record carries its arrival number
   assign new_entry.chrom = req_word.chromosome;
   assign new_entry.pos   = req_word.position;
   assign new_entry.idx   = IDX_W'(count_ff);

   // group boundaries come from comparing the two head slots
   assign head_end_run = !cell_valid[1];
   assign head_end_grp = head_end_run ||
                         !gsk_pkg::key_same(cell_entry[0], cell_entry[1]);

   for (genvar i = 0; i < MAX_VARIANTS; i++) begin : g_chain
      gsk_pkg::entry_type prev_e, next_e;
      logic               prev_v, prev_t, next_v;
      if (i == 0) begin : g_first
         assign prev_e = new_entry;
         assign prev_v = 1'b0;
         assign prev_t = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[i-1];
         assign prev_v = cell_valid[i-1];
         assign prev_t = cell_take[i-1];
      end
      if (i == MAX_VARIANTS - 1) begin : g_last
         assign next_e = new_entry;
         assign next_v = 1'b0;
      end else begin : g_inner
         assign next_e = cell_entry[i+1];
         assign next_v = cell_valid[i+1];
      end
      gsk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .prev_valid (prev_v),
         .prev_take  (prev_t),
         .next_entry (next_e),
         .next_valid (next_v),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .take       (cell_take[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsk_pkg::ST_LOAD: begin
            if (accept && req_word.last_record) begin
               state_in = gsk_pkg::ST_DRAIN;
            end
         end
         gsk_pkg::ST_DRAIN: begin
            if (pop && head_end_run) begin
               state_in = gsk_pkg::ST_LOAD;
            end
         end
         default: state_in = gsk_pkg::ST_LOAD;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      pop         = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      unique case (state_ff)
         gsk_pkg::ST_LOAD: begin
            req_ready   = 1'b1;
            ctrl.insert = req_valid && !full;
         end
         gsk_pkg::ST_DRAIN: begin
            // head goes out whenever the output register is free
            pop        = !rsp_valid_ff || rsp_ready;
            ctrl.drain = pop;
         end
         default: ;
      endcase
   end

   // load count and overflow bookkeeping
   always_comb begin
      count_in    = count_ff;
      ovf_seen_in = ovf_seen_ff;
      ovf_hold_in = ovf_hold_ff;
      if (accept) begin
         if (req_word.last_record) begin
            count_in    = '0;
            ovf_seen_in = 1'b0;
            ovf_hold_in = ovf_seen_ff || full;
         end else if (full) begin
            ovf_seen_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // output register and group numbering
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.group_chrom    = cell_entry[0].chrom;
         rsp_word_in.group_position = cell_entry[0].pos;
         rsp_word_in.variant_index  = cell_entry[0].idx;
         rsp_word_in.group_number   = grp_ff;
         rsp_word_in.end_of_group   = head_end_grp;
         rsp_word_in.end_of_run     = head_end_run;
         rsp_word_in.overflow       = ovf_hold_ff;
         if (head_end_run) begin
            grp_in = '0;
         end else if (head_end_grp) begin
            grp_in = grp_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsk_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_seen_ff  <= 1'b0;
         ovf_hold_ff  <= 1'b0;
         grp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_seen_ff  <= ovf_seen_in;
         ovf_hold_ff  <= ovf_hold_in;
         grp_ff       <= grp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
